### hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside reset
`define SVS_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next clock, outside reset
`define SVS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/svs_pkg.sv
package svs_pkg;

	typedef enum logic {
		REQ_ASSIGN = 1'b0,
		REQ_READ   = 1'b1
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// flags carried along the scan chain
	typedef struct packed {
		logic hit;
		logic have_free;
	} scan_flags_t;

	// slot update broadcast to all cells
	typedef struct packed {
		logic en;
		logic keep;
	} slot_cmd_t;

endpackage

### hw/rtl/svs_cell.sv
module svs_cell #(
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32,
	parameter int SLOT_W     = 4,
	parameter int SLOT_ID    = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tok_valid_in,
	input  logic [INDEX_BITS-1:0]     tok_pos_in,
	input  svs_pkg::scan_flags_t      tok_flags_in,
	input  logic [SLOT_W-1:0]         tok_hit_slot_in,
	input  logic [SLOT_W-1:0]         tok_free_slot_in,
	input  logic [VALUE_BITS-1:0]     tok_rd_in,
	output logic                      tok_valid_out,
	output logic [INDEX_BITS-1:0]     tok_pos_out,
	output svs_pkg::scan_flags_t      tok_flags_out,
	output logic [SLOT_W-1:0]         tok_hit_slot_out,
	output logic [SLOT_W-1:0]         tok_free_slot_out,
	output logic [VALUE_BITS-1:0]     tok_rd_out,
	input  svs_pkg::slot_cmd_t        wr_cmd,
	input  logic [SLOT_W-1:0]         wr_slot,
	input  logic [INDEX_BITS-1:0]     wr_pos,
	input  logic [VALUE_BITS-1:0]     wr_val
);

	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(SLOT_ID);

	logic                  valid_q;
	logic [INDEX_BITS-1:0] pos_q;
	logic [VALUE_BITS-1:0] val_q;

	logic                  tok_valid_q;
	logic [INDEX_BITS-1:0] tok_pos_q;
	svs_pkg::scan_flags_t  tok_flags_q;
	logic [SLOT_W-1:0]     tok_hit_slot_q;
	logic [SLOT_W-1:0]     tok_free_slot_q;
	logic [VALUE_BITS-1:0] tok_rd_q;

	logic new_hit;
	logic new_free;
	logic wr_here;

	assign new_hit  = !tok_flags_in.hit && valid_q && (pos_q == tok_pos_in);
	assign new_free = !tok_flags_in.have_free && !valid_q;
	assign wr_here  = wr_cmd.en && (wr_slot == MY_SLOT);

	// slot storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr_here) begin
			valid_q <= wr_cmd.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here && wr_cmd.keep) begin
			pos_q <= wr_pos;
			val_q <= wr_val;
		end
	end

	// scan token stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_q <= 1'b0;
		end else begin
			tok_valid_q <= tok_valid_in;
		end
	end

	always_ff @(posedge clk) begin
		tok_pos_q           <= tok_pos_in;
		tok_flags_q.hit       <= tok_flags_in.hit || new_hit;
		tok_flags_q.have_free <= tok_flags_in.have_free || new_free;
		tok_hit_slot_q      <= new_hit ? MY_SLOT : tok_hit_slot_in;
		tok_free_slot_q     <= new_free ? MY_SLOT : tok_free_slot_in;
		tok_rd_q            <= new_hit ? val_q : tok_rd_in;
	end

	assign tok_valid_out     = tok_valid_q;
	assign tok_pos_out       = tok_pos_q;
	assign tok_flags_out     = tok_flags_q;
	assign tok_hit_slot_out  = tok_hit_slot_q;
	assign tok_free_slot_out = tok_free_slot_q;
	assign tok_rd_out        = tok_rd_q;

endmodule

### hw/rtl/sparse_vector_store.sv
// path: a request walks the chain of slot cells, is captured in the end registers, then is
// resolved into the output register; in_stall holds off a new request until the scan token,
// walking one slot cell per cycle along the chain, is through and the output register is free
// reset: arst_n clears all slot valid bits, length and entry count at once
// no clearing pass; the block accepts a request as soon as reset is released
`include "assert_macros.svh"

module sparse_vector_store #(
	parameter int CAPACITY   = 16,
	parameter int INDEX_BITS = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 req_type,
	input  logic [INDEX_BITS-1:0]                position,
	input  logic signed [VALUE_BITS-1:0]         coefficient,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [VALUE_BITS-1:0]         read_value,
	output logic                                 found,
	output logic                                 overflow,
	output logic [INDEX_BITS:0]                  vector_length,
	output logic [$clog2(CAPACITY+1)-1:0]        nonzero_count
);

	localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W  = $clog2(CAPACITY + 1);

	svs_pkg::state_t state_q, state_d;

	logic                  tok_valid     [0:CAPACITY];
	logic [INDEX_BITS-1:0] tok_pos       [0:CAPACITY];
	svs_pkg::scan_flags_t  tok_flags     [0:CAPACITY];
	logic [SLOT_W-1:0]     tok_hit_slot  [0:CAPACITY];
	logic [SLOT_W-1:0]     tok_free_slot [0:CAPACITY];
	logic [VALUE_BITS-1:0] tok_rd        [0:CAPACITY];

	svs_pkg::req_kind_t    req_kind_q;
	logic [VALUE_BITS-1:0] coef_q;

	logic [INDEX_BITS-1:0] end_pos_q;
	svs_pkg::scan_flags_t  end_flags_q;
	logic [SLOT_W-1:0]     end_hit_slot_q;
	logic [SLOT_W-1:0]     end_free_slot_q;
	logic [VALUE_BITS-1:0] end_rd_q;

	logic [INDEX_BITS:0] len_q, len_d;
	logic [CNT_W-1:0]    cnt_q, cnt_d;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_rd_q;
	logic                  out_found_q;
	logic                  out_ovf_q;
	logic [INDEX_BITS:0]   out_len_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic                  in_accept;
	logic                  fire;
	logic                  is_read;
	logic                  coef_nz;
	logic                  ovf_d;
	svs_pkg::slot_cmd_t    wr_cmd;
	logic [SLOT_W-1:0]     wr_slot;

	assign in_accept = in_valid && !in_stall;

	// scan chain head
	assign tok_valid[0]     = in_accept;
	assign tok_pos[0]       = position;
	assign tok_flags[0]     = '0;
	assign tok_hit_slot[0]  = '0;
	assign tok_free_slot[0] = '0;
	assign tok_rd[0]        = '0;

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		svs_cell #(
			.INDEX_BITS (INDEX_BITS),
			.VALUE_BITS (VALUE_BITS),
			.SLOT_W     (SLOT_W),
			.SLOT_ID    (k)
		) u_cell (
			.clk               (clk),
			.arst_n            (arst_n),
			.tok_valid_in      (tok_valid[k]),
			.tok_pos_in        (tok_pos[k]),
			.tok_flags_in      (tok_flags[k]),
			.tok_hit_slot_in   (tok_hit_slot[k]),
			.tok_free_slot_in  (tok_free_slot[k]),
			.tok_rd_in         (tok_rd[k]),
			.tok_valid_out     (tok_valid[k+1]),
			.tok_pos_out       (tok_pos[k+1]),
			.tok_flags_out     (tok_flags[k+1]),
			.tok_hit_slot_out  (tok_hit_slot[k+1]),
			.tok_free_slot_out (tok_free_slot[k+1]),
			.tok_rd_out        (tok_rd[k+1]),
			.wr_cmd            (wr_cmd),
			.wr_slot           (wr_slot),
			.wr_pos            (end_pos_q),
			.wr_val            (coef_q)
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			svs_pkg::ST_IDLE: begin
				if (in_accept) begin
					state_d = svs_pkg::ST_SCAN;
				end
			end
			svs_pkg::ST_SCAN: begin
				if (tok_valid[CAPACITY]) begin
					state_d = svs_pkg::ST_FINISH;
				end
			end
			svs_pkg::ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					state_d = svs_pkg::ST_IDLE;
				end
			end
			default: state_d = svs_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		fire     = 1'b0;
		case (state_q)
			svs_pkg::ST_IDLE:   in_stall = 1'b0;
			svs_pkg::ST_SCAN:   in_stall = 1'b1;
			svs_pkg::ST_FINISH: fire = !out_valid_q || !out_stall;
			default:            in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= svs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_kind_q <= svs_pkg::req_kind_t'(req_type);
			coef_q     <= coefficient;
		end
		if (tok_valid[CAPACITY]) begin
			end_pos_q       <= tok_pos[CAPACITY];
			end_flags_q     <= tok_flags[CAPACITY];
			end_hit_slot_q  <= tok_hit_slot[CAPACITY];
			end_free_slot_q <= tok_free_slot[CAPACITY];
			end_rd_q        <= tok_rd[CAPACITY];
		end
	end

	// request resolution
	assign is_read = (req_kind_q == svs_pkg::REQ_READ);
	assign coef_nz = (coef_q != '0);

	always_comb begin
		wr_cmd  = '0;
		wr_slot = end_hit_slot_q;
		len_d   = len_q;
		cnt_d   = cnt_q;
		ovf_d   = 1'b0;
		if (fire && !is_read) begin
			if (end_flags_q.hit) begin
				wr_cmd.en   = 1'b1;
				wr_cmd.keep = coef_nz;
				if (!coef_nz) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
			end else if (coef_nz) begin
				if (end_flags_q.have_free) begin
					wr_cmd.en   = 1'b1;
					wr_cmd.keep = 1'b1;
					wr_slot     = end_free_slot_q;
					cnt_d       = cnt_q + CNT_W'(1);
					if ({1'b0, end_pos_q} >= len_q) begin
						len_d = {1'b0, end_pos_q} + (INDEX_BITS+1)'(1);
					end
				end else begin
					ovf_d = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			cnt_q <= '0;
		end else if (fire) begin
			len_q <= len_d;
			cnt_q <= cnt_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_rd_q    <= (is_read && end_flags_q.hit) ? end_rd_q : '0;
			out_found_q <= end_flags_q.hit;
			out_ovf_q   <= ovf_d;
			out_len_q   <= len_d;
			out_cnt_q   <= cnt_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_value    = out_rd_q;
	assign found         = out_found_q;
	assign overflow      = out_ovf_q;
	assign vector_length = out_len_q;
	assign nonzero_count = out_cnt_q;

	`SVS_ASSERT(a_end_tok_in_scan, clk, arst_n, !tok_valid[CAPACITY] || (state_q == svs_pkg::ST_SCAN), "scan token left chain outside scan")
	`SVS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`SVS_ASSERT(a_cnt_moves_on_fire, clk, arst_n, $stable(cnt_q) || $past(fire), "entry count changed without a request")
	`SVS_ASSERT(a_ovf_full, clk, arst_n, !(out_valid_q && out_ovf_q) || (out_cnt_q == CNT_W'(CAPACITY)), "overflow reported with free slots")
	`SVS_ASSERT_NEXT(a_fire_out, clk, arst_n, fire, out_valid_q, "resolved request produced no result")

endmodule

### tb/sparse_vector_store_test.sv
module sparse_vector_store_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 16;
	localparam int POS_W = 16;
	localparam int COEF_W = 32;
	localparam int COUNT_W = $clog2(SLOTS + 1);
	localparam int RANDOM_ITEMS = 1569;
	localparam int HOLD_CYCLES = 300;

	typedef struct {
		logic signed [COEF_W-1:0] value;
		logic                     hit;
		logic                     dropped;
		logic [POS_W:0]           vec_length;
		logic [COUNT_W-1:0]       entries;
	} coeff_result_t;

	// predicted table contents and the queue of results still owed by the block
	class coeff_table_book;
		bit                 occupied[SLOTS];
		logic [POS_W-1:0]   slot_pos[SLOTS];
		logic [COEF_W-1:0]  slot_val[SLOTS];
		logic [POS_W:0]     vec_length;
		logic [COUNT_W-1:0] entries;
		coeff_result_t      awaited[$];
		int mismatches = 0;
		int checked = 0;
		int reads = 0;
		int hits = 0;
		int drops = 0;
		int removals = 0;

		function new();
			vec_length = '0;
			entries = '0;
			foreach (occupied[k]) begin
				occupied[k] = 1'b0;
				slot_pos[k] = '0;
				slot_val[k] = '0;
			end
		endfunction

		function void note_request(svs_pkg::req_kind_t kind, logic [POS_W-1:0] pos,
				logic [COEF_W-1:0] coef);
			coeff_result_t r;
			bit hit, have_free;
			int hit_slot, free_slot;
			hit = 1'b0;
			have_free = 1'b0;
			hit_slot = 0;
			free_slot = 0;
			r.value = '0;
			r.dropped = 1'b0;
			for (int k = 0; k < SLOTS; k++) begin
				if (occupied[k]) begin
					if (!hit && slot_pos[k] == pos) begin
						hit = 1'b1;
						hit_slot = k;
					end
				end else if (!have_free) begin
					have_free = 1'b1;
					free_slot = k;
				end
			end
			if (kind == svs_pkg::REQ_READ) begin
				reads++;
				if (hit)
					r.value = slot_val[hit_slot];
			end else if (hit) begin
				if (coef != '0) begin
					slot_val[hit_slot] = coef;
				end else begin
					occupied[hit_slot] = 1'b0;
					entries = entries - 1'b1;
					removals++;
				end
			end else if (coef != '0) begin
				if (have_free) begin
					occupied[free_slot] = 1'b1;
					slot_pos[free_slot] = pos;
					slot_val[free_slot] = coef;
					entries = entries + 1'b1;
					if ({1'b0, pos} >= vec_length)
						vec_length = {1'b0, pos} + 1'b1;
				end else begin
					r.dropped = 1'b1;
					drops++;
				end
			end
			hits += hit;
			r.hit = hit;
			r.vec_length = vec_length;
			r.entries = entries;
			awaited = {awaited, r};
		endfunction

		function void report(string field, longint want, longint got);
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d",
				$time, field, want, got);
		endfunction

		function void check_result(coeff_result_t got);
			coeff_result_t want;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual value %0d length %0d",
					$time, got.value, got.vec_length);
				return;
			end
			want = awaited.pop_front();
			if (got.value !== want.value)
				report("read_value", want.value, got.value);
			if (got.hit !== want.hit)
				report("found", want.hit, got.hit);
			if (got.dropped !== want.dropped)
				report("overflow", want.dropped, got.dropped);
			if (got.vec_length !== want.vec_length)
				report("vector_length", want.vec_length, got.vec_length);
			if (got.entries !== want.entries)
				report("nonzero_count", want.entries, got.entries);
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		// a random stored position, or the fallback when the table is empty
		function logic [POS_W-1:0] stored_or(logic [POS_W-1:0] fallback);
			int used[$];
			foreach (occupied[k])
				if (occupied[k])
					used = {used, k};
			if (used.size() == 0)
				return fallback;
			return slot_pos[used[$urandom_range(0, used.size() - 1)]];
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      req_type;
	logic [POS_W-1:0]          position;
	logic signed [COEF_W-1:0]  coefficient;
	logic                      out_valid;
	logic                      out_stall;
	logic signed [COEF_W-1:0]  read_value;
	logic                      found;
	logic                      overflow;
	logic [POS_W:0]            vector_length;
	logic [COUNT_W-1:0]        nonzero_count;

	coeff_table_book book;
	int sent = 0;
	int results_seen = 0;

	sparse_vector_store #(
		.CAPACITY(SLOTS),
		.INDEX_BITS(POS_W),
		.VALUE_BITS(COEF_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.position(position),
		.coefficient(coefficient),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.found(found),
		.overflow(overflow),
		.vector_length(vector_length),
		.nonzero_count(nonzero_count)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [COEF_W-1:0] nonzero_coef();
		logic [COEF_W-1:0] c;
		case ($urandom_range(0, 9))
			0: c = 32'h8000_0000;
			1: c = 32'h7fff_ffff;
			2: c = 32'hffff_ffff;
			3: c = 32'h0000_0001;
			default: c = $urandom();
		endcase
		if (c == '0)
			c = 32'h0000_0001;
		return c;
	endfunction

	// one request transaction; valid stays high across back-to-back requests
	task automatic send_request(svs_pkg::req_kind_t kind, logic [POS_W-1:0] pos,
			logic [COEF_W-1:0] coef);
		int gap;
		gap = ((sent / 100) % 4 == 3) ? 0 : $urandom_range(0, 8);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		position <= pos;
		coefficient <= coef;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		book.note_request(kind, pos, coef);
		sent++;
	endtask

	// result side, with two long hold-offs that back the block up
	initial begin
		coeff_result_t got;
		int pause;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (results_seen == 40 || results_seen == 900)
				pause = HOLD_CYCLES;
			else if ((results_seen / 100) % 4 == 1)
				pause = 0;
			else
				pause = $urandom_range(0, 8);
			if (pause > 0) begin
				@(negedge clk);
				out_stall <= 1'b1;
				repeat (pause) @(negedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			got.value = read_value;
			got.hit = found;
			got.dropped = overflow;
			got.vec_length = vector_length;
			got.entries = nonzero_count;
			book.check_result(got);
			results_seen++;
		end
	end

	initial begin
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] base;
		logic [COEF_W-1:0] coef;
		svs_pkg::req_kind_t kind;
		int dice;
		in_valid = 1'b0;
		req_type = svs_pkg::REQ_ASSIGN;
		position = '0;
		coefficient = '0;
		arst_n = 1'b0;
		book = new();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, absent removal, inserts below and above the length
		send_request(svs_pkg::REQ_READ, 16'd0, 32'h0000_0000);
		send_request(svs_pkg::REQ_READ, 16'hffff, 32'hffff_ffff);
		send_request(svs_pkg::REQ_ASSIGN, 16'd5, 32'h0000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'd0, 32'h7fff_ffff);
		send_request(svs_pkg::REQ_ASSIGN, 16'd3, 32'h8000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'd1, 32'hffff_ffff);
		send_request(svs_pkg::REQ_READ, 16'd3, 32'h0000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'd3, 32'h0000_0001);
		send_request(svs_pkg::REQ_ASSIGN, 16'd1, 32'h0000_0000);
		send_request(svs_pkg::REQ_READ, 16'd1, 32'h1234_5678);
		// fill every slot, then overflow
		for (int p = 4; p < 18; p++)
			send_request(svs_pkg::REQ_ASSIGN, POS_W'(p), nonzero_coef());
		send_request(svs_pkg::REQ_ASSIGN, 16'd20, 32'h0000_00aa);
		send_request(svs_pkg::REQ_READ, 16'd20, 32'h0000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'd0, 32'h0000_0000);

		// window of new positions drifts upward so the length keeps growing
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			dice = $urandom_range(0, 99);
			base = (n * 40 > 65000) ? 16'd65000 : POS_W'(n * 40);
			pos = base + POS_W'($urandom_range(0, 31));
			kind = svs_pkg::REQ_ASSIGN;
			coef = '0;
			if (dice < 30) begin
				kind = svs_pkg::REQ_READ;
				coef = $urandom();
				if (dice < 15)
					pos = book.stored_or(pos);
				else if (dice >= 23)
					pos = POS_W'($urandom_range(0, 65535));
			end else if (dice < 55) begin
				coef = nonzero_coef();
			end else if (dice < 70) begin
				pos = book.stored_or(pos);
				coef = nonzero_coef();
			end else if (dice < 90) begin
				pos = book.stored_or(pos);
			end else begin
				pos = POS_W'($urandom_range(0, 65535));
			end
			send_request(kind, pos, coef);
		end

		// top position last, so the length reaches its maximum
		send_request(svs_pkg::REQ_ASSIGN, book.stored_or(16'd0), 32'h0000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'hffff, 32'h5a5a_5a5a);
		send_request(svs_pkg::REQ_READ, 16'hffff, 32'h0000_0000);
		send_request(svs_pkg::REQ_ASSIGN, 16'hffff, 32'h0000_0000);
		@(negedge clk);
		in_valid <= 1'b0;

		while (book.pending() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("%0d requests, %0d results checked: %0d reads, %0d found, %0d removals",
			sent, book.checked, book.reads, book.hits, book.removals);
		$display("%0d inserts dropped on a full table, final length %0d with %0d entries",
			book.drops, book.vec_length, book.entries);
		if (book.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

### sparse_vector_store.f
+incdir+hw/rtl
hw/rtl/svs_pkg.sv
hw/rtl/svs_cell.sv
hw/rtl/sparse_vector_store.sv
tb/sparse_vector_store_test.sv
